### rtl/ccr_pkg.sv
// Shared types, fixed-point constants and the sRGB linearization table
// for the contrast ratio block. No dependencies.
`default_nettype none

package ccr_pkg;

  // Fixed-point formats
  localparam int unsigned LUM_FRAC_BITS   = 16;
  localparam int unsigned RATIO_FRAC_BITS = 11;

  localparam int unsigned COLOR_W  = 24;
  localparam int unsigned RATIO_W  = 16;
  // linear light and luminance reach exactly 1.0, so one integer bit
  localparam int unsigned LUM_W    = LUM_FRAC_BITS + 1;
  localparam int unsigned PROD_W   = LUM_W + LUM_FRAC_BITS;
  localparam int unsigned ACC_W    = PROD_W + 1;
  // the ratio never reaches 32.0
  localparam int unsigned INT_BITS = 5;
  localparam int unsigned QUO_W    = INT_BITS + RATIO_FRAC_BITS;

  // Luminance weights and the 0.05 offset, round-half-up
  localparam logic [LUM_FRAC_BITS-1:0] W_RED =
    LUM_FRAC_BITS'(((64'd2126 << LUM_FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic [LUM_FRAC_BITS-1:0] W_GREEN =
    LUM_FRAC_BITS'(((64'd7152 << LUM_FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic [LUM_FRAC_BITS-1:0] W_BLUE =
    LUM_FRAC_BITS'(((64'd722 << LUM_FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic [LUM_W-1:0] LUM_OFF =
    LUM_W'(((64'd5 << LUM_FRAC_BITS) + 64'd50) / 64'd100);

  // Ratio of exactly 1.0
  localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(64'd1 << RATIO_FRAC_BITS);

  typedef struct packed {
    logic [COLOR_W-1:0] color_a;
    logic [COLOR_W-1:0] color_b;
    logic               restart;
  } pair_t;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic [RATIO_W-1:0] worst_so_far;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LUM,
    ST_DIV,
    ST_HOLD
  } ccr_state_t;

  typedef logic [255:0][LUM_W-1:0] lin_table_t;

  // One table entry: sRGB channel code to linear light in Q1.LUM_FRAC_BITS.
  // Evaluated only at elaboration.
  function automatic logic [LUM_W-1:0] lin_entry(input logic [8:0] c);
    logic [63:0] cv;
    logic [63:0] one;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] r;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] q;
    logic [63:0] p;
    logic [63:0] y;
    logic [63:0] e;
    cv  = 64'(c);
    one = 64'd1 << LUM_FRAC_BITS;
    r   = 64'd0;
    if (cv <= 64'd10) begin
      // linear segment near black
      e = (((cv << LUM_FRAC_BITS) * 64'd10) + 64'd16473) / 64'd32946;
    end else if (cv >= 64'd255) begin
      e = one;
    end else begin
      // x = (v + 0.055) / 1.055 in Q0.32, then x^2.4 = x^2 * x^(2/5)
      x  = (((64'd1000 * cv + 64'd14025) << 32) + 64'd134512) / 64'd269025;
      x2 = (x * x) >> 32;
      // fifth root of x^2, one bit at a time
      for (int k = 31; k >= 0; k--) begin
        t = r | (64'd1 << k);
        s = (t * t) >> 32;
        q = (s * s) >> 32;
        p = (q * t) >> 32;
        if (p <= x2) begin
          r = t;
        end
      end
      y = (x2 * r) >> 32;
      e = (y + (64'd1 << (31 - LUM_FRAC_BITS))) >> (32 - LUM_FRAC_BITS);
      if (e > one) begin
        e = one;
      end
    end
    return LUM_W'(e);
  endfunction

  function automatic lin_table_t build_lin_table();
    lin_table_t tbl;
    for (int i = 0; i < 256; i++) begin
      tbl[i] = lin_entry(9'(i));
    end
    return tbl;
  endfunction

  localparam lin_table_t LIN_TABLE = build_lin_table();

endpackage

`default_nettype wire

### rtl/color_contrast_ratio.sv
// Contrast ratio of two sRGB colors with a running minimum over an audit.
// Top level: sequencer, result register, running minimum. Depends on
// ccr_pkg, ccr_lum and ccr_div.
//
// Each pair item carries two 0xRRGGBB colors and a restart flag; each
// result item carries the pair's contrast ratio in unsigned Q5.11 (1.0 to
// 21.0) and the smallest ratio seen since the last restart, this pair
// included. After reset the minimum starts at all ones, so the first pair
// reports its own ratio. The block works on one pair at a time: a new pair
// is accepted only after the current one has passed through the luminance
// unit (six table lookups and products through one multiplier, nine steps)
// and then the bit-serial divider, which produces one quotient bit per cycle.
// A finished result waits in the output register while the next pair is
// taken; a stalled output holds the sequencer only once the next result is
// ready.
`default_nettype none

module color_contrast_ratio import ccr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    pair_valid,
  output logic    pair_stall,
  input  pair_t   pair,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  ccr_state_t         state;
  ccr_state_t         state_next;
  logic               restart;
  logic [RATIO_W-1:0] running_worst;
  logic [RATIO_W-1:0] running_worst_next;
  logic               accept;
  logic               out_free;
  logic               load_out;
  logic               lum_start;
  logic               lum_done;
  logic [LUM_W-1:0]   lum_a;
  logic [LUM_W-1:0]   lum_b;
  logic               div_start;
  logic               div_done;
  logic [RATIO_W-1:0] div_ratio;

  ccr_lum u_lum (
    .clk     (clk),
    .rst     (rst),
    .start   (lum_start),
    .color_a (pair.color_a),
    .color_b (pair.color_b),
    .done    (lum_done),
    .lum_a   (lum_a),
    .lum_b   (lum_b)
  );

  ccr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .lum_a (lum_a),
    .lum_b (lum_b),
    .done  (div_done),
    .ratio (div_ratio)
  );

  assign accept   = pair_valid && !pair_stall;
  assign out_free = !result_valid || !result_stall;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept)   state_next = ST_LUM;
      ST_LUM:  if (lum_done) state_next = ST_DIV;
      ST_DIV:  if (div_done) state_next = out_free ? ST_IDLE : ST_HOLD;
      ST_HOLD: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    pair_stall = 1'b1;
    lum_start  = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        pair_stall = 1'b0;
        lum_start  = pair_valid;
      end
      ST_LUM:  div_start = lum_done;
      ST_DIV:  load_out  = div_done && out_free;
      ST_HOLD: load_out  = out_free;
      default: pair_stall = 1'b1;
    endcase
  end

  // Update the running minimum with this ratio
  assign running_worst_next = (restart || div_ratio < running_worst) ?
                              div_ratio : running_worst;

  // State, result handshake and running minimum
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      result_valid  <= 1'b0;
      running_worst <= {RATIO_W{1'b1}};
    end else begin
      state <= state_next;
      if (load_out) begin
        result_valid  <= 1'b1;
        running_worst <= running_worst_next;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Hold the restart flag and the result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      restart <= pair.restart;
    end
    if (load_out) begin
      result.ratio        <= div_ratio;
      result.worst_so_far <= running_worst_next;
    end
  end

  // The minimum never exceeds the ratio it was formed with
  a_worst_le_ratio: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.worst_so_far <= result.ratio)
    else $error("worst_so_far above ratio");

  // Every ratio is at least 1.0
  a_ratio_min: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.ratio >= RATIO_ONE)
    else $error("ratio below 1.0");

  // Luminance finishes only while the sequencer waits for it
  a_lum_done_state: assert property (@(posedge clk) disable iff (rst)
    lum_done |-> state == ST_LUM)
    else $error("luminance done outside its phase");

  // The divider finishes only while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider done outside its phase");

  // A result loaded on a restart pair reports its own ratio as the minimum
  a_restart_min: assert property (@(posedge clk) disable iff (rst)
    load_out && restart |=> result.worst_so_far == result.ratio)
    else $error("restart did not reset the minimum");

endmodule

`default_nettype wire

### rtl/ccr_lum.sv
// Luminance unit: six table lookups and weighted products, one a cycle,
// accumulated into the luminance of both colors. Depends on ccr_pkg.
`default_nettype none

module ccr_lum import ccr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [COLOR_W-1:0] color_a,
  input  logic [COLOR_W-1:0] color_b,
  output logic               done,
  output logic [LUM_W-1:0]   lum_a,
  output logic [LUM_W-1:0]   lum_b
);

  // Step numbers: lookup at step j, product at j+1, accumulate at j+2
  localparam logic [3:0] STEP_A_FIRST = 4'd2;
  localparam logic [3:0] STEP_B_FIRST = 4'd5;
  localparam logic [3:0] STEP_A_DONE  = 4'd5;
  localparam logic [3:0] STEP_LAST    = 4'd8;

  logic                     active;
  logic [3:0]               cnt;
  logic [COLOR_W-1:0]       col_a;
  logic [COLOR_W-1:0]       col_b;
  logic [7:0]               chan;
  logic [LUM_FRAC_BITS-1:0] wsel;
  logic [LUM_W-1:0]         lin;
  logic [LUM_FRAC_BITS-1:0] wgt;
  logic [PROD_W-1:0]        prod;
  logic [ACC_W-1:0]         acc;
  logic [ACC_W-1:0]         rnd;
  logic [LUM_W-1:0]         rnd_lum;

  // Pick the channel code and its weight for this step
  always_comb begin
    case (cnt)
      4'd0:    begin chan = col_a[23:16]; wsel = W_RED;   end
      4'd1:    begin chan = col_a[15:8];  wsel = W_GREEN; end
      4'd2:    begin chan = col_a[7:0];   wsel = W_BLUE;  end
      4'd3:    begin chan = col_b[23:16]; wsel = W_RED;   end
      4'd4:    begin chan = col_b[15:8];  wsel = W_GREEN; end
      4'd5:    begin chan = col_b[7:0];   wsel = W_BLUE;  end
      default: begin chan = col_b[7:0];   wsel = W_BLUE;  end
    endcase
  end

  // Round the weighted sum back to Q1.LUM_FRAC_BITS
  assign rnd     = acc + (ACC_W'(1) << (LUM_FRAC_BITS - 1));
  assign rnd_lum = LUM_W'(rnd >> LUM_FRAC_BITS);

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 4'd1;
        if (cnt == STEP_LAST) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // Lookup, multiply and accumulate stages
  always_ff @(posedge clk) begin
    if (start) begin
      col_a <= color_a;
      col_b <= color_b;
    end
    lin  <= LIN_TABLE[chan];
    wgt  <= wsel;
    prod <= PROD_W'(lin) * PROD_W'(wgt);
    if (active) begin
      if (cnt == STEP_A_FIRST || cnt == STEP_B_FIRST) begin
        acc <= ACC_W'(prod);
      end else if (cnt > STEP_A_FIRST && cnt < STEP_LAST) begin
        acc <= acc + ACC_W'(prod);
      end
      if (cnt == STEP_A_DONE) begin
        lum_a <= rnd_lum;
      end
      if (cnt == STEP_LAST) begin
        lum_b <= rnd_lum;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/ccr_div.sv
// Bit-serial restoring divider: (lighter+0.05)/(darker+0.05), one quotient
// bit a cycle, saturated to the ratio width. Depends on ccr_pkg.
`default_nettype none

module ccr_div import ccr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [LUM_W-1:0]   lum_a,
  input  logic [LUM_W-1:0]   lum_b,
  output logic               done,
  output logic [RATIO_W-1:0] ratio
);

  localparam int unsigned REM_W = LUM_W + 1;
  localparam int unsigned CNT_W = $clog2(QUO_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [LUM_W-1:0]   hi;
  logic [LUM_W-1:0]   lo;
  logic [LUM_W-1:0]   dend;
  logic [LUM_W-1:0]   dsor;
  logic [REM_W-1:0]   rem;
  logic [QUO_W-1:0]   shreg;
  logic [QUO_W-1:0]   quo;
  logic [REM_W-1:0]   trial;
  logic               fits;
  logic               sat;

  // Order the pair and add the offset
  always_comb begin
    if (lum_a >= lum_b) begin
      hi = lum_a;
      lo = lum_b;
    end else begin
      hi = lum_b;
      lo = lum_a;
    end
  end
  assign dend = hi + LUM_OFF;

  // One restoring step: shift in the next dividend bit, try a subtract
  assign trial = {rem[REM_W-2:0], shreg[QUO_W-1]};
  assign fits  = trial >= {1'b0, dsor};

  // Saturate when the quotient exceeds the ratio width
  assign sat   = |(quo >> RATIO_W);
  assign ratio = sat ? {RATIO_W{1'b1}} : RATIO_W'(quo);

  // Count quotient bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Load the operands, then shift the remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      dsor  <= lo + LUM_OFF;
      rem   <= REM_W'(dend >> INT_BITS);
      shreg <= {dend[INT_BITS-1:0], {RATIO_FRAC_BITS{1'b0}}};
      quo   <= '0;
    end else if (busy) begin
      rem   <= fits ? (trial - {1'b0, dsor}) : trial;
      shreg <= shreg << 1;
      quo   <= {quo[QUO_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire
